@@ design/tkh_pkg.sv @@
`timescale 1ns / 1ps
package tkh_pkg;

  localparam int ValueW = 32;
  localparam int IndexW = 4;
  localparam int KW     = 5;
  localparam int StepW  = 4;

  typedef logic signed [ValueW-1:0] value_t;
  typedef logic [IndexW-1:0]        index_t;
  typedef logic [KW-1:0]            k_t;
  typedef logic [StepW-1:0]         step_t;

  localparam k_t KReset = 5'd5;

  typedef enum logic [1:0] {HOLD_NONE, HOLD_IN, HOLD_OUT} hold_t;
  typedef enum logic [2:0] {RD_NONE, RD_ROOT, RD_PARENT, RD_CHILD, RD_POS} rd_t;
  typedef enum logic [1:0] {WR_NONE, WR_VAL, WR_RDA, WR_PICK} wr_t;
  typedef enum logic [2:0] {
    POS_HOLD, POS_ZERO, POS_CNT, POS_PARENT, POS_PICK, POS_INC
  } pos_op_t;
  typedef enum logic [1:0] {EMIT_NONE, EMIT_EMPTY, EMIT_ENTRY} emit_t;
  typedef enum logic [3:0] {
    C_NEVER, C_ALWAYS, C_READOUT, C_NOT_FULL, C_TAKE, C_LEAF,
    C_SWAP_DN, C_POS_ZERO, C_SWAP_UP, C_EMPTY, C_LAST
  } cond_t;

  typedef struct packed {
    hold_t   hold;
    rd_t     rd;
    wr_t     wr;
    pos_op_t pos_op;
    logic    cnt_inc;
    emit_t   emit;
    cond_t   cond;
    logic    neg;
    logic    gate;
    step_t   target;
  } ucode_t;

  localparam step_t ST_RO0      = 4'd0;
  localparam step_t ST_RO_EMPTY = 4'd1;
  localparam step_t ST_RO_RD    = 4'd2;
  localparam step_t ST_RO_EMIT  = 4'd3;
  localparam step_t ST_IDLE     = 4'd4;
  localparam step_t ST_DISP     = 4'd5;
  localparam step_t ST_FULL     = 4'd6;
  localparam step_t ST_SD_CHK   = 4'd7;
  localparam step_t ST_SD_RD    = 4'd8;
  localparam step_t ST_SD_CMP   = 4'd9;
  localparam step_t ST_SD_END   = 4'd10;
  localparam step_t ST_SU_RD    = 4'd11;
  localparam step_t ST_SU_CMP   = 4'd12;
  localparam step_t ST_SU_END   = 4'd13;

  function automatic ucode_t ucode(step_t step);
    ucode_t w;
    w = '{hold: HOLD_NONE, rd: RD_NONE, wr: WR_NONE, pos_op: POS_HOLD,
          cnt_inc: 1'b0, emit: EMIT_NONE, cond: C_NEVER, neg: 1'b0,
          gate: 1'b0, target: ST_IDLE};
    case (step)
      ST_RO0: begin
        w.cond = C_EMPTY; w.neg = 1'b1; w.target = ST_RO_RD;
      end
      ST_RO_EMPTY: begin
        w.hold = HOLD_OUT; w.emit = EMIT_EMPTY; w.cond = C_ALWAYS;
      end
      ST_RO_RD: begin
        w.rd = RD_POS;
      end
      ST_RO_EMIT: begin
        w.hold = HOLD_OUT; w.emit = EMIT_ENTRY; w.pos_op = POS_INC;
        w.cond = C_LAST; w.neg = 1'b1; w.target = ST_RO_RD;
      end
      ST_IDLE: begin
        w.hold = HOLD_IN; w.pos_op = POS_ZERO;
      end
      ST_DISP: begin
        w.rd = RD_ROOT; w.cond = C_READOUT; w.target = ST_RO0;
      end
      ST_FULL: begin
        w.pos_op = POS_CNT; w.cond = C_NOT_FULL; w.target = ST_SU_RD;
      end
      ST_SD_CHK: begin
        w.pos_op = POS_ZERO; w.cond = C_TAKE; w.neg = 1'b1;
      end
      ST_SD_RD: begin
        w.rd = RD_CHILD; w.cond = C_LEAF; w.target = ST_SD_END;
      end
      ST_SD_CMP: begin
        w.wr = WR_PICK; w.pos_op = POS_PICK; w.cond = C_SWAP_DN;
        w.gate = 1'b1; w.target = ST_SD_RD;
      end
      ST_SD_END: begin
        w.wr = WR_VAL; w.cond = C_ALWAYS;
      end
      ST_SU_RD: begin
        w.rd = RD_PARENT; w.cond = C_POS_ZERO; w.target = ST_SU_END;
      end
      ST_SU_CMP: begin
        w.wr = WR_RDA; w.pos_op = POS_PARENT; w.cond = C_SWAP_UP;
        w.gate = 1'b1; w.target = ST_SU_RD;
      end
      ST_SU_END: begin
        w.wr = WR_VAL; w.cnt_inc = 1'b1; w.cond = C_ALWAYS;
      end
      default: begin
        w.cond = C_ALWAYS;
      end
    endcase
    return w;
  endfunction

endpackage

@@ design/tkh_in_if.sv @@
`timescale 1ns / 1ps
interface tkh_in_if;
  import tkh_pkg::*;

  logic   valid;
  logic   ready;
  logic   mode;
  value_t value;

  modport source (output valid, output mode, output value, input ready);
  modport sink (input valid, input mode, input value, output ready);
endinterface

@@ design/tkh_out_if.sv @@
`timescale 1ns / 1ps
interface tkh_out_if;
  import tkh_pkg::*;

  logic   valid;
  logic   ready;
  value_t entry_value;
  index_t entry_index;
  logic   is_empty;
  logic   last;

  modport source (output valid, output entry_value, output entry_index,
                  output is_empty, output last, input ready);
  modport sink (input valid, input entry_value, input entry_index,
                input is_empty, input last, output ready);
endinterface

@@ design/streaming_top_k_min_heap_unit.sv @@
`timescale 1ns / 1ps
// Insert below capacity: the value is written at the end and sifted up toward the root.
// Insert when full: rejected unless above the root, else it replaces the root and sifts down, maybe to a leaf.
// Read-out: emits each stored entry in index order, or one empty marker, and can be held by an output stall.
// Each heap level takes one memory read, then a compare and write back.
// Synchronous reset clears control, fill count and sets k_reg to 5; store not cleared.
module streaming_top_k_min_heap_unit #(
  parameter int MAX_K = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write,
  input  tkh_pkg::k_t   cfg_data,
  tkh_in_if.sink        req,
  tkh_out_if.source     rsp
);
  import tkh_pkg::*;

  localparam int AW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int CW = $clog2(MAX_K + 1);
  localparam int IW = CW + 1;

  typedef logic [IW-1:0] pos_t;
  typedef logic [CW-1:0] cnt_t;

  value_t mem [MAX_K];
  value_t rda;
  value_t rdb;
  value_t val;
  logic   mode;
  k_t     k_reg;
  cnt_t   cnt;
  pos_t   pos;
  pos_t   pos_next;
  step_t  upc;
  step_t  upc_next;

  logic   out_valid;
  value_t out_value;
  index_t out_index;
  logic   out_empty;
  logic   out_last;

  ucode_t cw;
  cnt_t   cap;
  cnt_t   cap_cfg;
  pos_t   cap_w;
  pos_t   parent;
  pos_t   left;
  pos_t   right;
  pos_t   addr_a;
  logic   pick_r;
  value_t pick_val;
  pos_t   pick_pos;
  logic   is_last;
  logic   cond_true;
  logic   taken;
  logic   go;
  logic   act;
  logic   in_acc;
  logic   out_free;
  value_t wdata;

  function automatic cnt_t cap_of(k_t k);
    cnt_t c;
    if (k == '0) begin
      c = CW'(1);
    end else if (int'(k) > MAX_K) begin
      c = CW'(MAX_K);
    end else begin
      c = CW'(k);
    end
    return c;
  endfunction

  assign cw       = ucode(upc);
  assign cap      = cap_of(k_reg);
  assign cap_cfg  = cap_of(cfg_data);
  assign cap_w    = IW'(cap);
  assign parent   = (pos - IW'(1)) >> 1;
  assign left     = (pos << 1) + IW'(1);
  assign right    = (pos << 1) + IW'(2);
  assign pick_r   = (right < cap_w) && (rdb < rda);
  assign pick_val = pick_r ? rdb : rda;
  assign pick_pos = pick_r ? right : left;
  assign is_last  = (pos + IW'(1)) == IW'(cnt);
  assign in_acc   = req.valid && req.ready;
  assign out_free = !out_valid || rsp.ready;

  assign req.ready       = (cw.hold == HOLD_IN) && !rst;
  assign rsp.valid       = out_valid;
  assign rsp.entry_value = out_value;
  assign rsp.entry_index = out_index;
  assign rsp.is_empty    = out_empty;
  assign rsp.last        = out_last;

  always_comb begin
    case (cw.cond)
      C_NEVER:    cond_true = 1'b0;
      C_ALWAYS:   cond_true = 1'b1;
      C_READOUT:  cond_true = mode;
      C_NOT_FULL: cond_true = cnt < cap;
      C_TAKE:     cond_true = rda < val;
      C_LEAF:     cond_true = left >= cap_w;
      C_SWAP_DN:  cond_true = pick_val < val;
      C_POS_ZERO: cond_true = (pos == '0);
      C_SWAP_UP:  cond_true = val < rda;
      C_EMPTY:    cond_true = (cnt == '0);
      C_LAST:     cond_true = is_last;
      default:    cond_true = 1'b0;
    endcase
  end

  always_comb begin
    case (cw.hold)
      HOLD_IN:  go = in_acc;
      HOLD_OUT: go = out_free;
      default:  go = 1'b1;
    endcase
    taken = cond_true ^ cw.neg;
    act   = go && (!cw.gate || taken);
    if (!go) begin
      upc_next = upc;
    end else if (taken) begin
      upc_next = cw.target;
    end else begin
      upc_next = upc + StepW'(1);
    end
  end

  always_comb begin
    case (cw.pos_op)
      POS_ZERO:   pos_next = '0;
      POS_CNT:    pos_next = IW'(cnt);
      POS_PARENT: pos_next = parent;
      POS_PICK:   pos_next = pick_pos;
      POS_INC:    pos_next = pos + IW'(1);
      default:    pos_next = pos;
    endcase
  end

  always_comb begin
    case (cw.rd)
      RD_ROOT:   addr_a = '0;
      RD_PARENT: addr_a = parent;
      RD_CHILD:  addr_a = left;
      default:   addr_a = pos;
    endcase
    case (cw.wr)
      WR_RDA:  wdata = rda;
      WR_PICK: wdata = pick_val;
      default: wdata = val;
    endcase
  end

  always_ff @(posedge clk) begin
    if (go && cw.rd != RD_NONE) begin
      rda <= mem[addr_a[AW-1:0]];
    end
    if (go && cw.rd == RD_CHILD) begin
      rdb <= mem[right[AW-1:0]];
    end
    if (act && cw.wr != WR_NONE) begin
      mem[pos[AW-1:0]] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode <= req.mode;
      val  <= req.value;
    end
    if (act) begin
      pos <= pos_next;
    end
    if (act && cw.emit == EMIT_EMPTY) begin
      out_value <= '0;
      out_index <= '0;
      out_empty <= 1'b1;
      out_last  <= 1'b1;
    end else if (act && cw.emit == EMIT_ENTRY) begin
      out_value <= rda;
      out_index <= IndexW'(pos);
      out_empty <= 1'b0;
      out_last  <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc       <= ST_IDLE;
      cnt       <= '0;
      k_reg     <= KReset;
      out_valid <= 1'b0;
    end else begin
      upc <= upc_next;
      if (cfg_write) begin
        k_reg <= cfg_data;
        if (cnt > cap_cfg) begin
          cnt <= cap_cfg;
        end
      end else if (act && cw.cnt_inc) begin
        cnt <= cnt + CW'(1);
      end
      if (act && cw.emit != EMIT_NONE) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ bench/streaming_top_k_min_heap_unit_tb.sv @@
`timescale 1ns / 1ps
module streaming_top_k_min_heap_unit_tb;
  import tkh_pkg::*;

  localparam int MaxK      = 16;
  localparam int CycleCap  = 900000;
  localparam int DrainWait = 40;
  localparam logic ModeInsert  = 1'b0;
  localparam logic ModeReadout = 1'b1;

  typedef struct {
    value_t entry_value;
    index_t entry_index;
    logic   is_empty;
    logic   last;
  } entry_t;

  logic clk;
  logic rst;
  logic cfg_write;
  k_t   cfg_data;

  tkh_in_if  req_if ();
  tkh_out_if rsp_if ();

  streaming_top_k_min_heap_unit #(.MAX_K(MaxK)) u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .req       (req_if),
    .rsp       (rsp_if)
  );

  value_t heap_model [MaxK];
  int     fill_model;
  k_t     k_model;
  entry_t pending_entries [$];

  int  errors;
  int  cycles;
  int  n_inserts;
  int  n_readouts;
  int  n_results;
  int  n_settings;
  bit  src_gaps_on;
  bit  sink_gaps_on;
  int  hold_off_left;
  int  stall_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int cap_of(k_t k);
    if (k == '0) return 1;
    if (k > MaxK) return MaxK;
    return int'(k);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 15);
    if (r < 9) return 0;
    if (r < 14) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic value_t rand_value();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7fffffff;
          1: return 32'sh80000000;
          2: return 32'sh0;
          default: return -32'sd1;
        endcase
      end
      1, 2: return $signed($urandom_range(0, 15)) - 32'sd8;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    if (errors < 50) $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic heap_insert(value_t v);
    int kk;
    int c;
    int p;
    int l;
    int r;
    int ch;
    value_t t;
    kk = cap_of(k_model);
    if (fill_model < kk) begin
      c = fill_model;
      heap_model[c] = v;
      while (c != 0) begin
        p = (c - 1) / 2;
        if (heap_model[c] < heap_model[p]) begin
          t = heap_model[c];
          heap_model[c] = heap_model[p];
          heap_model[p] = t;
        end
        c = p;
      end
      fill_model++;
    end else if (heap_model[0] < v) begin
      p = 0;
      heap_model[0] = v;
      forever begin
        l = 2 * p + 1;
        r = 2 * p + 2;
        if (l >= kk) break;
        if (r >= kk) ch = l;
        else ch = (heap_model[r] < heap_model[l]) ? r : l;
        if (heap_model[ch] < heap_model[p]) begin
          t = heap_model[ch];
          heap_model[ch] = heap_model[p];
          heap_model[p] = t;
        end
        p = ch;
      end
    end
  endtask

  task automatic heap_readout();
    entry_t e;
    if (fill_model == 0) begin
      e.entry_value = '0;
      e.entry_index = '0;
      e.is_empty    = 1'b1;
      e.last        = 1'b1;
      pending_entries.push_back(e);
    end else begin
      for (int i = 0; i < fill_model; i++) begin
        e.entry_value = heap_model[i];
        e.entry_index = index_t'(i);
        e.is_empty    = 1'b0;
        e.last        = (i + 1 == fill_model);
        pending_entries.push_back(e);
      end
    end
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(logic mode, value_t v);
    int gap;
    gap = src_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid = 1'b1;
    req_if.mode  = mode;
    req_if.value = v;
    do @(posedge clk); while (!req_if.ready);
    if (mode == ModeInsert) begin
      heap_insert(v);
      n_inserts++;
    end else begin
      heap_readout();
      n_readouts++;
    end
    @(negedge clk);
  endtask

  task automatic wait_idle();
    req_if.valid = 1'b0;
    while (pending_entries.size() != 0) @(negedge clk);
    repeat (DrainWait) @(negedge clk);
  endtask

  task automatic write_k(k_t v);
    wait_idle();
    cfg_write = 1'b1;
    cfg_data  = v;
    @(negedge clk);
    cfg_write = 1'b0;
    k_model = v;
    if (fill_model > cap_of(v)) fill_model = cap_of(v);
    n_settings++;
  endtask

  task automatic test_empty_readout();
    send_request(ModeReadout, $urandom);
  endtask

  task automatic test_default_capacity();
    send_request(ModeInsert, 32'sh7fffffff);
    send_request(ModeInsert, 32'sh80000000);
    send_request(ModeInsert, 32'sh0);
    send_request(ModeInsert, -32'sd1);
    send_request(ModeInsert, 32'sd1);
    send_request(ModeReadout, 32'sh0);
    // full: equal to root, above root, above root
    send_request(ModeInsert, 32'sh80000000);
    send_request(ModeInsert, -32'sd1);
    send_request(ModeInsert, 32'sd5);
    send_request(ModeReadout, $urandom);
  endtask

  task automatic test_capacity_limits();
    write_k(5'd0);
    send_request(ModeInsert, 32'sd100);
    send_request(ModeInsert, -32'sd100);
    send_request(ModeReadout, 32'sh0);
    write_k(5'd31);
    send_request(ModeInsert, 32'sd3);
    send_request(ModeInsert, 32'sd3);
    send_request(ModeInsert, 32'sh80000000);
    send_request(ModeReadout, 32'sh0);
    write_k(5'd3);
    send_request(ModeReadout, 32'sh0);
  endtask

  task automatic test_backpressure();
    write_k(5'd16);
    src_gaps_on  = 1'b0;
    sink_gaps_on = 1'b1;
    repeat (16) send_request(ModeInsert, rand_value());
    hold_off_left = 300;
    for (int i = 0; i < 8; i++) begin
      send_request(ModeReadout, $urandom);
      send_request(ModeInsert, rand_value());
    end
    src_gaps_on = 1'b1;
  endtask

  task automatic test_random_stream();
    k_t settings [10];
    settings = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd2, 5'd8, 5'd16, 5'd3, 5'd5, 5'd1};
    for (int ph = 0; ph < 10; ph++) begin
      if (ph >= 7) write_k(k_t'($urandom_range(0, 31)));
      else write_k(settings[ph]);
      src_gaps_on  = (ph != 3);
      sink_gaps_on = (ph != 3) && (ph != 6);
      for (int n = 0; n < 19; n++) begin
        if ($urandom_range(0, 4) == 0) send_request(ModeReadout, $urandom);
        else send_request(ModeInsert, rand_value());
      end
      send_request(ModeReadout, $urandom);
    end
  endtask

  initial begin
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_data      = KReset;
    req_if.valid  = 1'b0;
    req_if.mode   = ModeInsert;
    req_if.value  = '0;
    errors        = 0;
    n_inserts     = 0;
    n_readouts    = 0;
    n_results     = 0;
    n_settings    = 0;
    src_gaps_on   = 1'b1;
    sink_gaps_on  = 1'b1;
    hold_off_left = 0;
    fill_model    = 0;
    k_model       = KReset;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_readout();
    test_default_capacity();
    test_capacity_limits();
    test_backpressure();
    test_random_stream();

    req_if.valid = 1'b0;
    while (pending_entries.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    $display("Covered %0d inserts and %0d read-outs over %0d capacity writes,",
             n_inserts, n_readouts, n_settings);
    $display("with %0d results checked under random stalls and a long hold-off.",
             n_results);
    if (errors == 0) begin
      $display("streaming_top_k_min_heap_unit_tb: clean");
    end else begin
      $display("streaming_top_k_min_heap_unit_tb: errors");
    end
    $finish;
  end

  // response side: random stalls plus an optional long hold-off
  initial begin
    rsp_if.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        rsp_if.ready = 1'b0;
        hold_off_left--;
      end else if (stall_left > 0) begin
        rsp_if.ready = 1'b0;
        stall_left--;
      end else if (sink_gaps_on && $urandom_range(0, 3) == 0) begin
        rsp_if.ready = 1'b0;
        stall_left   = pick_gap();
      end else begin
        rsp_if.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_result
    entry_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (pending_entries.size() == 0) begin
        report_mismatch($sformatf("unexpected result value %0d index %0d",
                                  rsp_if.entry_value, rsp_if.entry_index));
      end else begin
        want = pending_entries.pop_front();
        n_results++;
        if (rsp_if.is_empty !== want.is_empty)
          report_mismatch($sformatf("is_empty %b, want %b", rsp_if.is_empty, want.is_empty));
        if (rsp_if.last !== want.last)
          report_mismatch($sformatf("last %b, want %b at index %0d",
                                    rsp_if.last, want.last, want.entry_index));
        if (rsp_if.entry_index !== want.entry_index)
          report_mismatch($sformatf("entry_index %0d, want %0d",
                                    rsp_if.entry_index, want.entry_index));
        if (rsp_if.entry_value !== want.entry_value)
          report_mismatch($sformatf("entry_value %0d, want %0d at index %0d",
                                    rsp_if.entry_value, want.entry_value,
                                    want.entry_index));
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CycleCap) begin
      @(posedge clk);
      cycles++;
    end
    $display("streaming_top_k_min_heap_unit_tb: errors");
    $finish;
  end

endmodule
